// ===== hdl/lfsa_pkg.sv =====
// Shared types and constants for the lattice fit scorer.
// Used by lfsa_mul, lfsa_ctrl and lattice_fit_score_assign; depends on nothing.
package lfsa_pkg;

    localparam int ENTRY_BITS = 21;
    localparam int FRAC_BITS  = 38;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ROW_BITS   = 3 * ENTRY_BITS;
    localparam int CFG_W      = ROW_BITS;
    localparam int STEP_W     = 4;

    // Last step of the multiply sequence.
    localparam logic [STEP_W-1:0] STEP_LAST = 4'd12;

    // Label pattern for an unassigned vector.
    localparam logic [15:0] LABEL_NONE = 16'hFFFF;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_ROW_ZERO  = 3'd0,
        REG_ROW_ONE   = 3'd1,
        REG_ROW_TWO   = 3'd2,
        REG_TOLERANCE = 3'd3,
        REG_LABEL     = 3'd4
    } lfsa_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } lfsa_state_t;

    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic [31:0]        prior_error;
        logic signed [15:0] prior_label;
        logic               last_item;
    } lfsa_in_t;

    typedef struct packed {
        logic signed [15:0] new_label;
        logic [31:0]        new_error;
        logic               matched;
        logic [23:0]        match_total;
    } lfsa_out_t;

    // Per-cycle control from the sequencer to the datapath.
    typedef struct packed {
        logic [1:0] mul_row;
        logic [1:0] mul_col;
        logic       mul_sq;
        logic [1:0] sq_idx;
        logic       h_start;
        logic       h_add;
        logic       t_load;
        logic [1:0] t_idx;
        logic       e_start;
        logic       e_add;
        logic       finish;
    } lfsa_ctrl_t;

endpackage

// ===== hdl/lattice_fit_score_assign.sv =====
// Lattice fit scorer: each accepted input beat takes twelve passes through the single shared
// multiplier plus accumulate slots before out_valid. A new beat is accepted only while the
// sequencer is idle, after the previous item has moved to the output register; a
// stalled output holds the next item in its final step until the slot frees.
// Reset clears all configuration registers, the match counter and the handshake state.
// Depends on lfsa_pkg, lfsa_mul and lfsa_ctrl.
module lattice_fit_score_assign
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lfsa_pkg::lfsa_in_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lfsa_pkg::lfsa_out_t           out_data,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [lfsa_pkg::CFG_W-1:0]    cfg_data
);

    localparam int EB = lfsa_pkg::ENTRY_BITS;
    localparam int FB = lfsa_pkg::FRAC_BITS;
    localparam int MW = lfsa_pkg::MUL_W;
    localparam int PW = lfsa_pkg::PROD_W;

    // Configuration registers.
    logic [lfsa_pkg::ROW_BITS-1:0] row_reg [3];
    logic [31:0]                   tol_reg;
    logic [14:0]                   label_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= '0;
            row_reg[1] <= '0;
            row_reg[2] <= '0;
            tol_reg    <= '0;
            label_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lfsa_pkg::REG_ROW_ZERO:  row_reg[0] <= cfg_data;
                lfsa_pkg::REG_ROW_ONE:   row_reg[1] <= cfg_data;
                lfsa_pkg::REG_ROW_TWO:   row_reg[2] <= cfg_data;
                lfsa_pkg::REG_TOLERANCE: tol_reg    <= cfg_data[31:0];
                lfsa_pkg::REG_LABEL:     label_reg  <= cfg_data[14:0];
                default:                 tol_reg    <= tol_reg;
            endcase
        end
    end

    // Sequencer.
    lfsa_pkg::lfsa_ctrl_t ctrl;
    logic                 in_acc;
    logic                 out_free;
    logic                 out_valid_reg;

    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    lfsa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_acc),
        .out_free (out_free),
        .ready    (in_ready),
        .ctrl     (ctrl)
    );

    // Input beat is held for the whole computation.
    lfsa_pkg::lfsa_in_t item_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            item_reg <= in_data;
        end
    end

    // Operand selection for the shared multiplier.
    logic [31:0]               t_reg [3];
    logic [lfsa_pkg::ROW_BITS-1:0] row_sel;
    logic signed [EB-1:0]      entry_sel;
    logic signed [31:0]        g_sel;
    logic signed [MW-1:0]      mul_a;
    logic signed [MW-1:0]      mul_b;
    logic signed [PW-1:0]      prod;

    always_comb
    begin
        case (ctrl.mul_row)
            2'd1:    row_sel = row_reg[1];
            2'd2:    row_sel = row_reg[2];
            default: row_sel = row_reg[0];
        endcase
        case (ctrl.mul_col)
            2'd1:
            begin
                entry_sel = row_sel[EB +: EB];
                g_sel     = item_reg.vec_y;
            end
            2'd2:
            begin
                entry_sel = row_sel[2*EB +: EB];
                g_sel     = item_reg.vec_z;
            end
            default:
            begin
                entry_sel = row_sel[0 +: EB];
                g_sel     = item_reg.vec_x;
            end
        endcase
        if (ctrl.mul_sq)
        begin
            mul_a = signed'({1'b0, t_reg[ctrl.sq_idx]});
            mul_b = signed'({1'b0, t_reg[ctrl.sq_idx]});
        end
        else
        begin
            mul_a = MW'(entry_sel);
            mul_b = MW'(g_sel);
        end
    end

    lfsa_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Row accumulator: only the fractional 38 bits of the dot product matter.
    logic [FB-1:0] hacc_reg;
    logic [FB-1:0] hacc_next;

    always_comb
    begin
        hacc_next = hacc_reg;
        if (ctrl.h_start)
        begin
            hacc_next = prod[FB-1:0];
        end
        else if (ctrl.h_add)
        begin
            hacc_next = hacc_reg + prod[FB-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        hacc_reg <= hacc_next;
    end

    // Distance to the nearest integer, truncated to 32 fractional bits.
    logic [FB-1:0] half_dist;

    always_comb
    begin
        if (hacc_reg <= (FB'(1) << (FB - 1)))
        begin
            half_dist = hacc_reg;
        end
        else
        begin
            half_dist = ~hacc_reg + FB'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.t_load)
        begin
            t_reg[ctrl.t_idx] <= half_dist[FB-1:FB-32];
        end
    end

    // Error accumulator over the three squares, scaled 2^64.
    logic [63:0] eacc_reg;
    logic [63:0] eacc_next;

    always_comb
    begin
        eacc_next = eacc_reg;
        if (ctrl.e_start)
        begin
            eacc_next = prod[63:0];
        end
        else if (ctrl.e_add)
        begin
            eacc_next = eacc_reg + prod[63:0];
        end
    end

    always_ff @(posedge clk)
    begin
        eacc_reg <= eacc_next;
    end

    // Decision, label update and match count.
    logic [31:0]            err;
    logic                   hit;
    logic [COUNT_BITS-1:0]  cnt_reg;
    logic [COUNT_BITS-1:0]  cnt_after;
    logic [COUNT_BITS-1:0]  cnt_next;
    logic [COUNT_BITS+23:0] cnt_wide;
    lfsa_pkg::lfsa_out_t    result;

    always_comb
    begin
        err       = eacc_reg[63:32];
        hit       = (err < tol_reg) && (err < item_reg.prior_error);
        cnt_after = cnt_reg;
        if (hit && (cnt_reg != '1))
        begin
            cnt_after = cnt_reg + 1'b1;
        end
        cnt_next = item_reg.last_item ? '0 : cnt_after;
        cnt_wide = (COUNT_BITS + 24)'(cnt_after);

        result.new_label   = item_reg.prior_label;
        result.new_error   = item_reg.prior_error;
        result.matched     = hit;
        result.match_total = cnt_wide[23:0];
        if (hit)
        begin
            result.new_label = signed'({1'b0, label_reg});
            result.new_error = err;
        end
        else if (item_reg.prior_label == signed'({1'b0, label_reg}))
        begin
            result.new_label = signed'(lfsa_pkg::LABEL_NONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.finish)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Output register.
    lfsa_pkg::lfsa_out_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    // A new beat is never taken back to back with the previous one.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("input accepted while an item is in progress");

    // A result appears only from the sequencer's finish step.
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctrl.finish))
        else $error("output valid without a finished item");

    // A matched result always carries a real label.
    a_match_label: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.matched) |-> !out_data.new_label[15])
        else $error("matched result with unassigned label");

    // The finish step never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !ctrl.finish)
        else $error("result overwritten before it was taken");
`endif

endmodule

// ===== hdl/lfsa_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on lfsa_pkg for operand and product widths.
module lfsa_mul
(
    input  logic                               clk,
    input  logic signed [lfsa_pkg::MUL_W-1:0]  a,
    input  logic signed [lfsa_pkg::MUL_W-1:0]  b,
    output logic signed [lfsa_pkg::PROD_W-1:0] prod
);

    logic signed [lfsa_pkg::PROD_W-1:0] prod_reg;

    // One product per cycle, registered before any accumulation.
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/lfsa_ctrl.sv =====
// Sequencer that steps the shared multiplier through nine matrix products
// and three squares per vector. Depends on lfsa_pkg for the state and control types.
module lfsa_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   out_free,
    output logic                   ready,
    output lfsa_pkg::lfsa_ctrl_t   ctrl
);

    lfsa_pkg::lfsa_state_t           state_reg;
    lfsa_pkg::lfsa_state_t           state_next;
    logic [lfsa_pkg::STEP_W-1:0]     step_reg;
    logic [lfsa_pkg::STEP_W-1:0]     step_next;

    // State and step registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfsa_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state: run the fixed step sequence, then wait for a free output slot.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            lfsa_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (start)
                begin
                    state_next = lfsa_pkg::ST_RUN;
                end
            end
            lfsa_pkg::ST_RUN:
            begin
                if (step_reg == lfsa_pkg::STEP_LAST)
                begin
                    state_next = lfsa_pkg::ST_DONE;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            lfsa_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = lfsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfsa_pkg::ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    // Outputs: decode the step into operand selects and accumulator strobes.
    always_comb
    begin
        ctrl        = '0;
        ready       = (state_reg == lfsa_pkg::ST_IDLE);
        ctrl.finish = (state_reg == lfsa_pkg::ST_DONE) && out_free;
        if (state_reg == lfsa_pkg::ST_RUN)
        begin
            // Multiplier issue: matrix products, then the three squares.
            case (step_reg)
                4'd0:    begin ctrl.mul_row = 2'd0; ctrl.mul_col = 2'd0; end
                4'd1:    begin ctrl.mul_row = 2'd0; ctrl.mul_col = 2'd1; end
                4'd2:    begin ctrl.mul_row = 2'd0; ctrl.mul_col = 2'd2; end
                4'd3:    begin ctrl.mul_row = 2'd1; ctrl.mul_col = 2'd0; end
                4'd4:    begin ctrl.mul_row = 2'd1; ctrl.mul_col = 2'd1; end
                4'd5:    begin ctrl.mul_row = 2'd1; ctrl.mul_col = 2'd2; end
                4'd6:    begin ctrl.mul_row = 2'd2; ctrl.mul_col = 2'd0; end
                4'd7:    begin ctrl.mul_row = 2'd2; ctrl.mul_col = 2'd1; end
                4'd8:    begin ctrl.mul_row = 2'd2; ctrl.mul_col = 2'd2; end
                4'd9:    begin ctrl.mul_sq = 1'b1; ctrl.sq_idx = 2'd0; end
                4'd10:   begin ctrl.mul_sq = 1'b1; ctrl.sq_idx = 2'd1; end
                4'd11:   begin ctrl.mul_sq = 1'b1; ctrl.sq_idx = 2'd2; end
                default: begin ctrl.mul_sq = 1'b0; end
            endcase

            // Row accumulator sees each product in the cycle after its issue.
            case (step_reg) inside
                4'd1, 4'd4, 4'd7:             ctrl.h_start = 1'b1;
                4'd2, 4'd3, 4'd5, 4'd6, 4'd8, 4'd9: ctrl.h_add = 1'b1;
                default:                      ctrl.h_add = 1'b0;
            endcase

            // Fold a finished row into its truncated remainder.
            case (step_reg)
                4'd4:    begin ctrl.t_load = 1'b1; ctrl.t_idx = 2'd0; end
                4'd7:    begin ctrl.t_load = 1'b1; ctrl.t_idx = 2'd1; end
                4'd10:   begin ctrl.t_load = 1'b1; ctrl.t_idx = 2'd2; end
                default: begin ctrl.t_load = 1'b0; end
            endcase

            // Error accumulator takes the squares.
            case (step_reg) inside
                4'd10:        ctrl.e_start = 1'b1;
                4'd11, 4'd12: ctrl.e_add = 1'b1;
                default:      ctrl.e_add = 1'b0;
            endcase
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for lattice_fit_score_assign: directed and random vector beats,
// a local fixed-point predictor of label, error and match count, and an in-order checker.
// Depends on lfsa_pkg and the scorer RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_BITS    = 24;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 10;
    localparam int PHASE_BEATS   = 50;

    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [2:0] REG_SPARE = 3'd5;

    localparam logic [lfsa_pkg::ENTRY_BITS-1:0] ENTRY_MAX = 21'h0F_FFFF;
    localparam logic [lfsa_pkg::ENTRY_BITS-1:0] ENTRY_MIN = 21'h10_0000;
    localparam logic [lfsa_pkg::ENTRY_BITS-1:0] ENTRY_ONE = 21'd1024;
    localparam logic [COUNT_BITS-1:0]           COUNT_FULL = '1;
    localparam logic [lfsa_pkg::FRAC_BITS-1:0]  HALF_UNIT = 38'h20_0000_0000;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    lfsa_pkg::lfsa_in_t         in_data   = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    lfsa_pkg::lfsa_out_t        out_data;
    logic                       cfg_we    = 1'b0;
    logic [2:0]                 cfg_index = lfsa_pkg::REG_ROW_ZERO;
    logic [lfsa_pkg::CFG_W-1:0] cfg_data  = '0;

    // Local copy of the configuration and of the match counter.
    logic [lfsa_pkg::ROW_BITS-1:0] fit_rows [3] = '{default: '0};
    logic [31:0]                   tol_sq       = '0;
    logic [14:0]                   grain        = '0;
    logic [COUNT_BITS-1:0]         match_count  = '0;

    lfsa_pkg::lfsa_in_t  vec_q [$];
    lfsa_pkg::lfsa_out_t fit_q [$];

    bit idle_on    = 1'b1;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;
    int send_gap   = 0;
    int recv_gap   = 0;
    int hold_left  = 0;
    int fail_count = 0;
    int cycle_count = 0;

    lattice_fit_score_assign #(.COUNT_BITS(COUNT_BITS)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Summed squared distance of matrix times g from the nearest integers, scaled 2^32.
    function automatic logic [31:0] fit_error(lfsa_pkg::lfsa_in_t b);
        logic signed [31:0]                     g [3];
        logic signed [lfsa_pkg::ENTRY_BITS-1:0] e;
        longint                                 h;
        logic [lfsa_pkg::FRAC_BITS-1:0]         f;
        logic [lfsa_pkg::FRAC_BITS-1:0]         m;
        logic [31:0]                            t;
        logic [63:0]                            acc;
        g[0] = b.vec_x;
        g[1] = b.vec_y;
        g[2] = b.vec_z;
        acc = '0;
        for (int r = 0; r < 3; r++)
        begin
            h = 0;
            for (int c = 0; c < 3; c++)
            begin
                e = fit_rows[r][lfsa_pkg::ENTRY_BITS*c +: lfsa_pkg::ENTRY_BITS];
                h += longint'(e) * longint'(g[c]);
            end
            // Distance to the nearest integer; a tie is half a unit either way.
            f = h[lfsa_pkg::FRAC_BITS-1:0];
            m = (f <= HALF_UNIT) ? f : -f;
            t = m[lfsa_pkg::FRAC_BITS-1:6];
            acc += 64'(t) * 64'(t);
        end
        return acc[63:32];
    endfunction

    // Work out the result of one accepted beat and queue it.
    function automatic void predict_fit(lfsa_pkg::lfsa_in_t b);
        lfsa_pkg::lfsa_out_t r;
        logic [31:0]         err;
        err = fit_error(b);
        r.new_label = b.prior_label;
        r.new_error = b.prior_error;
        r.matched   = 1'b0;
        if (err < tol_sq && err < b.prior_error)
        begin
            r.new_label = {1'b0, grain};
            r.new_error = err;
            r.matched   = 1'b1;
            if (match_count != COUNT_FULL)
                match_count++;
        end
        else if (b.prior_label == {1'b0, grain})
        begin
            r.new_label = lfsa_pkg::LABEL_NONE;
        end
        r.match_total = 24'(match_count);
        // The list ends here: the count starts over with the next beat.
        if (b.last_item)
            match_count = '0;
        fit_q.push_back(r);
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic lfsa_pkg::lfsa_in_t make_beat(logic [31:0] x, logic [31:0] y,
                                                     logic [31:0] z, logic [31:0] perr,
                                                     logic [15:0] plabel, logic last);
        lfsa_pkg::lfsa_in_t b;
        b.vec_x       = x;
        b.vec_y       = y;
        b.vec_z       = z;
        b.prior_error = perr;
        b.prior_label = plabel;
        b.last_item   = last;
        return b;
    endfunction

    // Whole number between -7 and 7 with jitter of random size.
    function automatic logic [31:0] lattice_coord();
        int          whole;
        logic [31:0] jitter;
        whole  = (int'($urandom_range(0, 14)) - 7) * (1 << 28);
        jitter = $signed($urandom) >>> $urandom_range(6, 31);
        return whole + jitter;
    endfunction

    // Row of small whole entries, now and then with a fractional part.
    function automatic logic [lfsa_pkg::ROW_BITS-1:0] int_row();
        logic [lfsa_pkg::ENTRY_BITS-1:0] e [3];
        for (int c = 0; c < 3; c++)
        begin
            e[c] = lfsa_pkg::ENTRY_BITS'((int'($urandom_range(0, 6)) - 3) * 1024);
            if ($urandom_range(0, 7) == 0)
                e[c] = e[c] + lfsa_pkg::ENTRY_BITS'($urandom_range(1, 1023));
        end
        return {e[2], e[1], e[0]};
    endfunction

    function automatic logic [lfsa_pkg::ROW_BITS-1:0] extreme_row();
        logic [lfsa_pkg::ENTRY_BITS-1:0] e [3];
        for (int c = 0; c < 3; c++)
        begin
            case ($urandom_range(0, 3))
                0:       e[c] = ENTRY_MAX;
                1:       e[c] = ENTRY_MIN;
                2:       e[c] = '0;
                default: e[c] = '1;
            endcase
        end
        return {e[2], e[1], e[0]};
    endfunction

    // Mostly vectors near the lattice, the rest raw bits.
    function automatic lfsa_pkg::lfsa_in_t random_beat(bit shaped);
        lfsa_pkg::lfsa_in_t b;
        if (shaped)
        begin
            b.vec_x = lattice_coord();
            b.vec_y = lattice_coord();
            b.vec_z = lattice_coord();
        end
        else
        begin
            b.vec_x = $urandom;
            b.vec_y = $urandom;
            b.vec_z = $urandom;
        end
        case ($urandom_range(0, 7))
            0, 1:    b.prior_error = '1;
            2:       b.prior_error = '0;
            3, 4:    b.prior_error = $urandom_range(0, 32'h0100_0000);
            default: b.prior_error = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0:       b.prior_label = {1'b0, grain};
            1:       b.prior_label = lfsa_pkg::LABEL_NONE;
            default: b.prior_label = 16'($urandom);
        endcase
        b.last_item = ($urandom_range(0, 9) == 0);
        return b;
    endfunction

    // One register write; the local copy follows the write.
    task automatic write_reg(logic [2:0] idx, logic [lfsa_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            lfsa_pkg::REG_ROW_ZERO:  fit_rows[0] = value;
            lfsa_pkg::REG_ROW_ONE:   fit_rows[1] = value;
            lfsa_pkg::REG_ROW_TWO:   fit_rows[2] = value;
            lfsa_pkg::REG_TOLERANCE: tol_sq      = value[31:0];
            lfsa_pkg::REG_LABEL:     grain       = value[14:0];
            default:                 ;
        endcase
    endtask

    // Unused upper bits of the narrow registers carry noise.
    task automatic load_setting(logic [lfsa_pkg::ROW_BITS-1:0] r0,
                                logic [lfsa_pkg::ROW_BITS-1:0] r1,
                                logic [lfsa_pkg::ROW_BITS-1:0] r2,
                                logic [31:0] tol, logic [14:0] lbl);
        write_reg(lfsa_pkg::REG_ROW_ZERO, r0);
        write_reg(lfsa_pkg::REG_ROW_ONE, r1);
        write_reg(lfsa_pkg::REG_ROW_TWO, r2);
        write_reg(lfsa_pkg::REG_TOLERANCE, {31'($urandom), tol});
        write_reg(lfsa_pkg::REG_LABEL, {$urandom, 16'($urandom), lbl});
    endtask

    // Wait until every queued beat went in and every result came out.
    task automatic drain();
        while (vec_q.size() != 0 || in_valid || fit_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Input driver: presents queued beats, with short idle bursts between them.
    always @(posedge clk or negedge rst_n)
    begin : drive_input
        logic take_next;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            take_next = !in_valid || in_ready;
            if (in_valid && in_ready)
                predict_fit(in_data);
            if (take_next)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (vec_q.size() != 0)
                begin
                    in_data  <= vec_q.pop_front();
                    in_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 3) == 0)
                        send_gap <= $urandom_range(1, 3);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output ready: one long hold-off on request, otherwise short random stalls.
    always @(posedge clk or negedge rst_n)
    begin : drive_ready
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap  <= recv_gap - 1;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            recv_gap  <= $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Result checker: each output beat against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        lfsa_pkg::lfsa_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (fit_q.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, out_data);
                fail_count++;
            end
            else
            begin
                want = fit_q.pop_front();
                compare_field("new_label", want.new_label, out_data.new_label);
                compare_field("new_error", want.new_error, out_data.new_error);
                compare_field("matched", want.matched, out_data.matched);
                compare_field("match_total", want.match_total, out_data.match_total);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [lfsa_pkg::ROW_BITS-1:0] rows [3];
        logic [31:0]                   tol;
        logic [14:0]                   lbl;
        int                            kind;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Identity matrix, widest tolerance, top label; then a write past the list.
        load_setting({42'd0, ENTRY_ONE}, {21'd0, ENTRY_ONE, 21'd0}, {ENTRY_ONE, 42'd0},
                     '1, 15'h7FFF);
        write_reg(REG_SPARE, '1);
        @(negedge clk);
        // Exact fit, then a zero prior error that blocks the fit and drops the label.
        vec_q.push_back(make_beat(0, 0, 0, '1, lfsa_pkg::LABEL_NONE, 1'b0));
        vec_q.push_back(make_beat(0, 0, 0, 0, 16'h7FFF, 1'b0));
        // Half-way ties on one and on all three components.
        vec_q.push_back(make_beat(32'h0800_0000, 0, 0, '1, 16'd5, 1'b0));
        vec_q.push_back(make_beat(32'h0800_0000, 32'h0800_0000, 32'h0800_0000, '1,
                                  16'h7FFF, 1'b0));
        // Extreme components and an out-of-range prior label.
        vec_q.push_back(make_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1,
                                  16'h8000, 1'b0));
        vec_q.push_back(make_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1,
                                  16'h7FFF, 1'b0));
        vec_q.push_back(make_beat('1, '1, '1, 32'd1, 16'h1234, 1'b0));
        // Near-integer vector closing the list, then a fresh list.
        vec_q.push_back(make_beat(32'h3000_0005, 32'hD000_0000, 32'h1000_0000,
                                  32'h8000_0000, lfsa_pkg::LABEL_NONE, 1'b1));
        vec_q.push_back(make_beat(0, 0, 0, '1, 16'h7FFF, 1'b1));
        drain();

        // Zero tolerance: nothing fits, a held label 0 is dropped.
        load_setting({42'd0, ENTRY_ONE}, {21'd0, ENTRY_ONE, 21'd0}, {ENTRY_ONE, 42'd0},
                     '0, 15'd0);
        @(negedge clk);
        vec_q.push_back(make_beat(0, 0, 0, '1, 16'd0, 1'b0));
        vec_q.push_back(make_beat(0, 0, 0, '1, lfsa_pkg::LABEL_NONE, 1'b1));
        vec_q.push_back(make_beat(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, '1,
                                  16'h8000, 1'b0));
        vec_q.push_back(make_beat(32'h2000_0000, 32'hE000_0000, 0, '1, 16'd0, 1'b1));
        drain();

        // Largest and smallest matrix entries.
        load_setting({3{ENTRY_MAX}}, {3{ENTRY_MIN}}, '1, '1, 15'h2AAA);
        @(negedge clk);
        vec_q.push_back(make_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '1,
                                  16'h2AAA, 1'b0));
        vec_q.push_back(make_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '1,
                                  lfsa_pkg::LABEL_NONE, 1'b0));
        vec_q.push_back(make_beat(0, 0, 0, '1, 16'h2AAA, 1'b0));
        vec_q.push_back(make_beat(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0400, '1,
                                  16'hFFFE, 1'b0));
        vec_q.push_back(make_beat(32'h1000_0000, 32'h1000_0000, 32'h1000_0000, '1,
                                  16'h2AAA, 1'b1));
        drain();

        // Random settings, each followed by a list of mostly near-lattice vectors.
        for (int p = 0; p < PHASES; p++)
        begin
            kind = $urandom_range(0, 4);
            for (int r = 0; r < 3; r++)
            begin
                case (kind)
                    3:       rows[r] = lfsa_pkg::ROW_BITS'({$urandom, $urandom});
                    4:       rows[r] = extreme_row();
                    default: rows[r] = int_row();
                endcase
            end
            case ($urandom_range(0, 5))
                0:       tol = '0;
                1:       tol = '1;
                2, 3:    tol = $urandom_range(0, 32'h1000_0000);
                default: tol = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       lbl = '0;
                1:       lbl = '1;
                default: lbl = 15'($urandom);
            endcase
            load_setting(rows[0], rows[1], rows[2], tol, lbl);
            @(negedge clk);
            // The last list runs with no idling at all.
            idle_on = (p != PHASES - 1) && ($urandom_range(0, 4) != 0);
            if (p == 1)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_BEATS; n++)
                vec_q.push_back(random_beat($urandom_range(0, 3) != 0));
            drain();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
